// ----- src/uuid_text_parser_assert.svh -----
// ----------------------------------------------------------------------------
// uuid_text_parser assertion macros
// concurrent assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef UUID_TEXT_PARSER_ASSERT_SVH
`define UUID_TEXT_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// plain property checked at every clock edge outside reset
`define UTP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication checked at every clock edge outside reset
`define UTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define UTP_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/utp_pkg.sv -----
// ----------------------------------------------------------------------------
// utp_pkg
// shared constants and types of the uuid text parser
// ----------------------------------------------------------------------------
`default_nettype none

package utp_pkg;

    localparam int UUID_BYTES = 16;
    localparam int COUNT_W    = 5;
    localparam int VALUE_W    = 8 * UUID_BYTES;
    localparam int WORD_W     = 64;

    localparam logic [7:0] CHAR_OPEN  = 8'h7B;  // '{'
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;  // '}'
    localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LF    = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UF    = 8'h46;  // 'F'

    typedef struct packed {
        logic       is_hex;
        logic       is_dash;
        logic       is_open;
        logic       is_close;
        logic [3:0] nibble;
    } char_class_t;

    typedef struct packed {
        logic [WORD_W-1:0] value_high;
        logic [WORD_W-1:0] value_low;
        logic              parse_ok;
    } parse_result_t;

endpackage

`default_nettype wire

// ----- src/utp_char_if.sv -----
// ----------------------------------------------------------------------------
// utp_char_if
// character channel: one text character per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface utp_char_if;

    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);

endinterface

`default_nettype wire

// ----- src/utp_result_if.sv -----
// ----------------------------------------------------------------------------
// utp_result_if
// result channel: one parsed uuid per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface utp_result_if;

    logic        valid;
    logic        ready;
    logic [63:0] value_high;
    logic [63:0] value_low;
    logic        parse_ok;

    modport source (output valid, output value_high, output value_low, output parse_ok,
                    input ready);
    modport sink   (input valid, input value_high, input value_low, input parse_ok,
                    output ready);

endinterface

`default_nettype wire

// ----- src/utp_char_decode.sv -----
// ----------------------------------------------------------------------------
// utp_char_decode
// classifies one character and gives its hex digit value
// ----------------------------------------------------------------------------
`default_nettype none

module utp_char_decode
    import utp_pkg::*;
(
    input  wire logic [7:0] character,
    output char_class_t     cls
);

    always_comb
    begin
        cls          = '0;
        cls.is_dash  = (character == CHAR_DASH);
        cls.is_open  = (character == CHAR_OPEN);
        cls.is_close = (character == CHAR_CLOSE);
        priority if (character >= CHAR_0 && character <= CHAR_9)
        begin
            cls.is_hex = 1'b1;
            cls.nibble = 4'(character - CHAR_0);
        end
        else if (character >= CHAR_LA && character <= CHAR_LF)
        begin
            cls.is_hex = 1'b1;
            cls.nibble = 4'(character - CHAR_LA + 8'd10);
        end
        else if (character >= CHAR_UA && character <= CHAR_UF)
        begin
            cls.is_hex = 1'b1;
            cls.nibble = 4'(character - CHAR_UA + 8'd10);
        end
        else
        begin
            cls.is_hex = 1'b0;
            cls.nibble = 4'd0;
        end
    end

endmodule

`default_nettype wire

// ----- src/utp_core.sv -----
// ----------------------------------------------------------------------------
// utp_core
// parse state and byte shift register, one character per step
// ----------------------------------------------------------------------------
`default_nettype none

module utp_core
    import utp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire char_class_t  cls,
    input  wire logic         last_char,
    output parse_result_t     result
);

`include "uuid_text_parser_assert.svh"

    logic [VALUE_W-1:0] store_reg, store_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         high_reg, high_next;
    logic               pending_reg, pending_next;
    logic               fail_reg, fail_next;
    logic               first_reg, first_next;
    logic               brace_reg, brace_next;
    logic               do_consume;
    logic               ok;

    // last character inside braces is checked, not parsed
    assign do_consume = last_char ? !brace_reg : !(first_reg && cls.is_open);

    always_comb
    begin
        store_next   = store_reg;
        count_next   = count_reg;
        high_next    = high_reg;
        pending_next = pending_reg;
        fail_next    = fail_reg;
        brace_next   = brace_reg;
        first_next   = 1'b0;

        if (!last_char && first_reg && cls.is_open)
            brace_next = 1'b1;
        if (last_char && brace_reg && !cls.is_close)
            fail_next = 1'b1;

        if (do_consume && !fail_reg && !cls.is_dash)
        begin
            priority if (!cls.is_hex)
                fail_next = 1'b1;
            else if (!pending_reg)
            begin
                high_next    = cls.nibble;
                pending_next = 1'b1;
            end
            else
            begin
                pending_next = 1'b0;
                if (count_reg[COUNT_W-1])
                    fail_next = 1'b1;
                else
                begin
                    store_next = {store_reg[VALUE_W-9:0], high_reg, cls.nibble};
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    assign ok = !fail_next && !pending_next && (count_next == COUNT_W'(UUID_BYTES));

    always_comb
    begin
        result.parse_ok   = ok;
        result.value_high = ok ? store_next[VALUE_W-1:WORD_W] : '0;
        result.value_low  = ok ? store_next[WORD_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            high_reg    <= '0;
            pending_reg <= 1'b0;
            fail_reg    <= 1'b0;
            first_reg   <= 1'b1;
            brace_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                // text done: back to the start state
                count_reg   <= '0;
                high_reg    <= '0;
                pending_reg <= 1'b0;
                fail_reg    <= 1'b0;
                first_reg   <= 1'b1;
                brace_reg   <= 1'b0;
            end
            else
            begin
                count_reg   <= count_next;
                high_reg    <= high_next;
                pending_reg <= pending_next;
                fail_reg    <= fail_next;
                first_reg   <= first_next;
                brace_reg   <= brace_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            store_reg <= store_next;
    end

    `UTP_ASSERT(a_count_range, clk, rst_n, count_reg <= COUNT_W'(UUID_BYTES), "byte count above 16")
    `UTP_ASSERT_IMP(a_first_clean, clk, rst_n, first_reg, !pending_reg && !fail_reg && count_reg == '0, "start state not clean")
    `UTP_ASSERT_IMP(a_last_restarts, clk, rst_n, $past(step && last_char), first_reg && !brace_reg, "no restart after last character")

endmodule

`default_nettype wire

// ----- src/uuid_text_parser.sv -----
// ----------------------------------------------------------------------------
// uuid_text_parser
// parses uuid text, one character per transfer, into a 128-bit value
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                              | transfer
//  ---------+-----+--------------------------------------+-------------------------
//  chars    | in  | character[7:0], last_char            | valid && ready
//  results  | out | value_high[63:0], value_low[63:0],   | valid && ready
//           |     | parse_ok                             |
//
//  one character per cycle sustained unless a last character waits on a held
//  result; a character is held in the input register, and a last character
//  goes from there into the result register when it advances, which raises
//  the result valid flag
//  rst_n clears the parse state, the input and the result valid flags
//  a held result stalls only a last character in the input register;
//  ordinary characters keep flowing while the result waits
//
`default_nettype none

module uuid_text_parser
    import utp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    utp_char_if.sink     chars,
    utp_result_if.source results
);

`include "uuid_text_parser_assert.svh"

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // result register
    logic          out_valid_reg, out_valid_next;
    parse_result_t out_reg;

    logic          accept;
    logic          adv;
    char_class_t   cls;
    parse_result_t core_result;

    // a non-last character never needs the result slot
    assign adv    = in_valid_reg && (!in_last_reg || !out_valid_reg || results.ready);
    assign accept = chars.valid && chars.ready;

    assign chars.ready = !in_valid_reg || adv;

    utp_char_decode u_decode
    (
        .character (in_char_reg),
        .cls       (cls)
    );

    utp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .cls       (cls),
        .last_char (in_last_reg),
        .result    (core_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv && in_last_reg)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg <= chars.character;
            in_last_reg <= chars.last_char;
        end
        if (adv && in_last_reg)
            out_reg <= core_result;
    end

    assign results.valid      = out_valid_reg;
    assign results.value_high = out_reg.value_high;
    assign results.value_low  = out_reg.value_low;
    assign results.parse_ok   = out_reg.parse_ok;

    `UTP_ASSERT_IMP(a_result_source, clk, rst_n, $rose(out_valid_reg), $past(adv && in_last_reg), "result without last character")
    `UTP_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid_reg && !out_reg.parse_ok, out_reg.value_high == '0 && out_reg.value_low == '0, "failed parse with nonzero value")
    `UTP_ASSERT_IMP(a_plain_no_stall, clk, rst_n, in_valid_reg && !in_last_reg, adv, "ordinary character stalled")

endmodule

`default_nettype wire

// ----- tb/uuid_parse_checker.sv -----
// ----------------------------------------------------------------------------
// uuid_parse_checker
// watches both channels of the uuid text parser, predicts every parse result
// from the accepted characters and compares it with the result transfers
// ----------------------------------------------------------------------------
`default_nettype none

module uuid_parse_checker
    import utp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    utp_char_if       chars,
    utp_result_if     results,
    output int        mismatches,
    output int        outstanding
);

    // predicted parse state of the text in flight
    logic [7:0]         byte_q [UUID_BYTES];
    logic [COUNT_W-1:0] n_bytes;
    logic [3:0]         pend_nib;
    logic               have_nib;
    logic               text_bad;
    logic               text_start;
    logic               in_braces;

    parse_result_t awaited[$];
    int            bad_count;

    // {is hex, nibble}
    function automatic logic [4:0] decode_hex(input logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9)
            return {1'b1, 4'(c - CHAR_0)};
        if (c >= CHAR_LA && c <= CHAR_LF)
            return {1'b1, 4'(c - CHAR_LA + 8'd10)};
        if (c >= CHAR_UA && c <= CHAR_UF)
            return {1'b1, 4'(c - CHAR_UA + 8'd10)};
        return 5'b0;
    endfunction

    task automatic clear_text();
        n_bytes    = '0;
        pend_nib   = '0;
        have_nib   = 1'b0;
        text_bad   = 1'b0;
        text_start = 1'b1;
        in_braces  = 1'b0;
    endtask

    // dashes are skipped, digits pair up into bytes, anything else spoils the text
    task automatic absorb_char(input logic [7:0] c);
        logic [4:0] d;
        d = decode_hex(c);
        if (text_bad || c == CHAR_DASH)
            return;
        if (!d[4])
        begin
            text_bad = 1'b1;
            return;
        end
        if (!have_nib)
        begin
            pend_nib = d[3:0];
            have_nib = 1'b1;
            return;
        end
        have_nib = 1'b0;
        if (n_bytes >= UUID_BYTES)
        begin
            text_bad = 1'b1;
            return;
        end
        byte_q[n_bytes[3:0]] = {pend_nib, d[3:0]};
        n_bytes++;
    endtask

    task automatic report_mismatch(input string what, input parse_result_t want,
                                   input parse_result_t got);
        bad_count++;
        if (bad_count <= 10)
            $display("%0t %s: expected high=%016h low=%016h ok=%0b, got high=%016h low=%016h ok=%0b",
                     $time, what, want.value_high, want.value_low, want.parse_ok,
                     got.value_high, got.value_low, got.parse_ok);
    endtask

    always @(posedge clk)
    begin : watch
        parse_result_t want;
        parse_result_t got;
        if (!rst_n)
        begin
            clear_text();
            awaited.delete();
            bad_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (chars.valid && chars.ready)
            begin
                if (!chars.last_char)
                begin
                    // an opening brace counts only as the first character
                    if (text_start && chars.character == CHAR_OPEN)
                        in_braces = 1'b1;
                    else
                        absorb_char(chars.character);
                    text_start = 1'b0;
                end
                else
                begin
                    if (in_braces)
                    begin
                        if (chars.character != CHAR_CLOSE)
                            text_bad = 1'b1;
                    end
                    else
                        absorb_char(chars.character);
                    want = '0;
                    want.parse_ok = !text_bad && !have_nib && n_bytes == UUID_BYTES;
                    if (want.parse_ok)
                        for (int i = 0; i < 8; i++)
                        begin
                            want.value_high = {want.value_high[55:0], byte_q[i]};
                            want.value_low  = {want.value_low[55:0], byte_q[i + 8]};
                        end
                    awaited.push_back(want);
                    clear_text();
                end
            end

            if (results.valid && results.ready)
            begin
                got.value_high = results.value_high;
                got.value_low  = results.value_low;
                got.parse_ok   = results.parse_ok;
                if (awaited.size() == 0)
                    report_mismatch("unexpected result", '0, got);
                else
                begin
                    want = awaited.pop_front();
                    if (got.value_high !== want.value_high || got.value_low !== want.value_low
                        || got.parse_ok !== want.parse_ok)
                        report_mismatch("result mismatch", want, got);
                end
            end

            mismatches  <= bad_count;
            outstanding <= awaited.size();
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_uuid_text_parser.sv -----
// ----------------------------------------------------------------------------
// tb_uuid_text_parser
// drives uuid texts into the parser: a directed set of edge texts, then random
// well-formed, damaged and noise texts under changing sender and receiver
// idling; a side checker predicts and compares every parse result
// ----------------------------------------------------------------------------
`default_nettype none

module tb_uuid_text_parser;
    import utp_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int RANDOM_CHARS = 60;
    localparam int RANDOM_TEXTS = 3;       // every text yields one result
    localparam int BURST_TEXTS  = 12;      // short texts sent into the hold-off
    localparam int DRAIN_CYCLES = 16;      // quiet time that watches for stray results

    logic clk = 1'b0;
    logic rst_n;

    // idle percentages per side; the receiver one is read by another process
    int   tx_idle_pct = 21;
    int   rx_idle_pct = 67;
    logic hold_go     = 1'b0;
    logic hold_active;

    int   mismatches;
    int   outstanding;
    int   cycle_count;

    logic [7:0] text_buf[$];  // characters of the next text; send_text marks the last one

    utp_char_if   chars();
    utp_result_if results();

    uuid_text_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    uuid_parse_checker parse_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .results     (results),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    // receiver: random back-pressure, fully closed while the hold-off runs
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            results.ready <= rst_n && !hold_active && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // hold-off counted in its own process so the sender keeps offering meanwhile
    initial
    begin
        hold_active = 1'b0;
        while (!hold_go)
            @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10)
            return CHAR_0 + {4'd0, v};
        return (upper ? CHAR_UA : CHAR_LA) + {4'd0, v} - 8'd10;
    endfunction

    // a random byte that is neither a hex digit nor a dash
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c inside {[CHAR_0:CHAR_9], [CHAR_LA:CHAR_LF], [CHAR_UA:CHAR_UF], CHAR_DASH})
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // one transfer; valid stays high into the next character unless an idle gap follows
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.character <= c;
        chars.last_char <= last;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic load_text(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic send_string(input string s);
        load_text(s);
        send_text();
    endtask

    // mostly well-formed uuids with random content, the rest damaged or plain noise
    task automatic build_random_text();
        int   pick;
        int   flaw;
        int   digits;
        int   spot;
        logic braced;
        logic canonical;
        text_buf.delete();
        pick      = $urandom_range(0, 99);
        flaw      = -1;
        digits    = 32;
        braced    = 1'($urandom_range(0, 1));
        canonical = 1'($urandom_range(0, 1));

        // noise: a few arbitrary bytes, salted with the characters that matter
        if (pick >= 90)
        begin
            repeat ($urandom_range(1, 6))
                case ($urandom_range(0, 5))
                    0:       text_buf.push_back(CHAR_OPEN);
                    1:       text_buf.push_back(CHAR_CLOSE);
                    2:       text_buf.push_back(CHAR_DASH);
                    3:       text_buf.push_back(hex_char(4'($urandom), 1'($urandom)));
                    default: text_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            return;
        end

        if (pick >= 60)
            flaw = $urandom_range(0, 5);
        case (flaw)
            0:       digits = $urandom_range(0, 1) ? 31 : 33;  // odd digit count
            1:       digits = $urandom_range(0, 1) ? 34 : 36;  // too many bytes
            2:       digits = 2 * $urandom_range(1, 15);       // too few bytes
            default: ;
        endcase

        if (braced)
            text_buf.push_back(CHAR_OPEN);
        for (int i = 0; i < digits; i++)
        begin
            if (canonical ? (i == 8 || i == 12 || i == 16 || i == 20)
                          : ($urandom_range(0, 9) == 0))
                text_buf.push_back(CHAR_DASH);
            text_buf.push_back(hex_char(4'($urandom), 1'($urandom)));
        end
        if (!canonical && $urandom_range(0, 3) == 0)
            text_buf.push_back(CHAR_DASH);

        if (flaw == 4)
        begin
            // brace mismatch: unclosed, wrongly closed, or closed but never opened
            if (!braced)
                text_buf.push_back(CHAR_CLOSE);
            else if ($urandom_range(0, 1))
                text_buf.push_back(8'($urandom_range(0, 255)));
        end
        else if (braced)
            text_buf.push_back(CHAR_CLOSE);

        if (flaw == 3)
        begin
            spot = $urandom_range(0, text_buf.size() - 1);
            text_buf.insert(spot, junk_char());
        end
        else if (flaw == 5)
        begin
            spot = $urandom_range(1, text_buf.size() - 1);
            text_buf.insert(spot, $urandom_range(0, 1) ? CHAR_OPEN : CHAR_CLOSE);
        end
    endtask

    initial
    begin : stimulus
        int random_chars;
        int text_no;

        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.character = '0;
        chars.last_char = 1'b0;
        random_chars    = 0;
        text_no         = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: value extremes, both cases, braces, and every way to fail
        send_string("00000000-0000-0000-0000-000000000000");
        send_string("FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF");
        send_string("{ffffffff-ffff-ffff-ffff-ffffffffffff}");
        send_string("0123456789abcdefABCDEF9876543210");
        send_string("{0123456789abcdef0123456789abcdef");      // opened, never closed
        send_string("{");                                      // lone brace is no opener
        send_string("}");
        send_string("-");
        send_string("0123456789abcdef0123456789abcdef01");     // seventeenth byte
        send_string("0123456789abcdef0123456789abcde");        // unpaired digit
        send_string("01234567-89ab-cdef-0123-456789abcdeg");   // non-hex at the end
        send_string("0123{4567-89ab-cdef-0123-456789abcdef");  // brace inside the text
        send_string("{01234567-89ab-cdef-0123-456789abcdef}}");
        send_string("-0-1-2-3-4-5-6-7-8-9-a-b-c-d-e-f-0-1-2-3-4-5-6-7-8-9-A-B-C-D-E-F-");
        // a non-hex byte first, then last: an early failure must swallow everything after it
        load_text("00112233445566778899aabbccddeeff");
        text_buf[0] = 8'hFF;
        send_text();
        load_text("00112233445566778899aabbccddeeff");
        text_buf[31] = 8'h00;
        send_text();

        while (random_chars < RANDOM_CHARS || text_no < RANDOM_TEXTS)
        begin
            if (text_no == RANDOM_TEXTS / 3)
            begin
                // swap the idling of the two sides
                tx_idle_pct = 67;
                rx_idle_pct <= 21;
            end
            if (text_no == 2 * RANDOM_TEXTS / 3)
            begin
                // no idling from here on; first close the receiver and pour in
                // short texts so results back up and the input stalls
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                hold_go <= 1'b1;
                repeat (BURST_TEXTS)
                begin
                    text_buf.delete();
                    text_buf.push_back(8'($urandom_range(0, 255)));
                    send_text();
                end
            end
            build_random_text();
            random_chars += text_buf.size();
            send_text();
            text_no++;
        end
        chars.valid <= 1'b0;

        // let the checker see the last transfer, drain, then watch for strays
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
